FILE: src/lsp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lsp_pkg
// Shared types, widths and constants of the laser scan to points block.
// ----------------------------------------------------------------------------
package lsp_pkg;

	localparam int RANGE_W      = 16;
	localparam int COORD_W      = 17;
	localparam int IDX_W        = 12;
	localparam int ANGLE_W      = 32;
	localparam int CORDIC_STEPS = 30;
	localparam int CORDIC_Q     = 30;
	localparam int CORDIC_W     = 34;
	localparam int STEP_W       = 4;
	localparam int STEP_PAIRS   = CORDIC_STEPS / 2;
	localparam int COORD_LIMIT  = 65535;

	localparam int MAX_SAMPLES_DEF = 4096;
	localparam int TRIG_FRAC_DEF   = 16;

	localparam logic [STEP_W-1:0]  STEP_LAST   = STEP_W'(STEP_PAIRS - 1);
	localparam logic [ANGLE_W-1:0] EIGHTH_TURN = 32'h2000_0000;
	localparam logic [31:0]        CORDIC_GAIN = 32'h26DD_3B6A;

	typedef struct packed {
		logic [RANGE_W-1:0]        gate_lo;
		logic [RANGE_W-1:0]        gate_hi;
		logic [ANGLE_W-1:0]        angle_start;
		logic [ANGLE_W-1:0]        angle_step;
		logic signed [COORD_W-1:0] x_min;
		logic signed [COORD_W-1:0] x_max;
		logic signed [COORD_W-1:0] y_min;
		logic signed [COORD_W-1:0] y_max;
	} lsp_cfg_t;

	typedef struct packed {
		logic              load;
		logic              angle;
		logic              setup;
		logic              iter;
		logic              trig;
		logic              mulx;
		logic              muly;
		logic              saty;
		logic              finish;
		logic [STEP_W-1:0] step;
	} lsp_cmd_t;

	typedef struct packed {
		logic out_free;
	} lsp_sts_t;

	function automatic logic [CORDIC_W-1:0] atan_turn(input logic [4:0] i);
		logic [31:0] a;
		unique case (i)
			5'd0:  a = 32'h20000000;
			5'd1:  a = 32'h12E4051D;
			5'd2:  a = 32'h09FB385B;
			5'd3:  a = 32'h051111D4;
			5'd4:  a = 32'h028B0D43;
			5'd5:  a = 32'h0145D7E1;
			5'd6:  a = 32'h00A2F61E;
			5'd7:  a = 32'h00517C55;
			5'd8:  a = 32'h0028BE53;
			5'd9:  a = 32'h00145F2E;
			5'd10: a = 32'h000A2F98;
			5'd11: a = 32'h000517CC;
			5'd12: a = 32'h00028BE6;
			5'd13: a = 32'h000145F3;
			5'd14: a = 32'h0000A2F9;
			5'd15: a = 32'h0000517C;
			5'd16: a = 32'h000028BE;
			5'd17: a = 32'h0000145F;
			5'd18: a = 32'h00000A2F;
			5'd19: a = 32'h00000517;
			5'd20: a = 32'h0000028B;
			5'd21: a = 32'h00000145;
			5'd22: a = 32'h000000A2;
			5'd23: a = 32'h00000051;
			5'd24: a = 32'h00000028;
			5'd25: a = 32'h00000014;
			5'd26: a = 32'h0000000A;
			5'd27: a = 32'h00000005;
			5'd28: a = 32'h00000002;
			5'd29: a = 32'h00000001;
			default: a = 32'h0;
		endcase
		return CORDIC_W'(a);
	endfunction

endpackage
`default_nettype wire

FILE: src/laser_scan_to_points_roi.sv
`default_nettype none
// ----------------------------------------------------------------------------
// laser_scan_to_points_roi
// Turns the range samples of a laser scan into Cartesian points and flags
// those that fall inside a rectangular workspace.
//
// Input channel: range_mm and last_sample with in_valid / in_stall. One beat
// per sample, in scan order; last_sample closes the scan and clears the
// sample counter. Output channel: kept, x_mm, y_mm, sample_index and
// end_of_scan with out_valid / out_stall, exactly one beat per input beat.
// The sample steps through the angle, setup, CORDIC, trig and scaling states,
// and the window check and output register are loaded in the done state; the
// CORDIC unit runs two of its 30 rotations per cycle. No new sample is taken
// before the current one is done, but the next sample is taken while a
// finished result still sits in the output register; a stalled result holds
// and the block waits only when a second result is ready to be written behind
// it. Reset clears the sample counter, the sequencer and the output valid,
// and loads the register defaults. Registers sit on the APB port at 4*index;
// the user must write them only while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module laser_scan_to_points_roi #(
	parameter int MAX_SAMPLES        = lsp_pkg::MAX_SAMPLES_DEF,
	parameter int TRIG_FRACTION_BITS = lsp_pkg::TRIG_FRAC_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic [lsp_pkg::RANGE_W-1:0]     range_mm,
	input  wire logic                            last_sample,
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	output logic                                 kept,
	output logic signed [lsp_pkg::COORD_W-1:0]   x_mm,
	output logic signed [lsp_pkg::COORD_W-1:0]   y_mm,
	output logic [lsp_pkg::IDX_W-1:0]            sample_index,
	output logic                                 end_of_scan,
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [4:0]                      paddr,
	input  wire logic [31:0]                     pwdata,
	output logic [31:0]                          prdata,
	output logic                                 pready
);
	import lsp_pkg::*;

	typedef enum logic [2:0] {
		REG_GATE_LO, REG_GATE_HI, REG_ANGLE_START, REG_ANGLE_STEP,
		REG_X_MIN, REG_X_MAX, REG_Y_MIN, REG_Y_MAX
	} reg_idx_t;

	lsp_cfg_t cfg_q;
	lsp_cmd_t cmd;
	lsp_sts_t sts;
	reg_idx_t reg_sel;
	logic     wr_en;

	assign reg_sel = reg_idx_t'(paddr[4:2]);
	assign wr_en   = psel && penable && pwrite;
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gate_lo     <= '0;
			cfg_q.gate_hi     <= 16'hFFFF;
			cfg_q.angle_start <= '0;
			cfg_q.angle_step  <= '0;
			cfg_q.x_min       <= 17'sd500;
			cfg_q.x_max       <= 17'sd1500;
			cfg_q.y_min       <= -17'sd500;
			cfg_q.y_max       <= 17'sd500;
		end else if (wr_en) begin
			unique case (reg_sel)
				REG_GATE_LO:     cfg_q.gate_lo     <= pwdata[RANGE_W-1:0];
				REG_GATE_HI:     cfg_q.gate_hi     <= pwdata[RANGE_W-1:0];
				REG_ANGLE_START: cfg_q.angle_start <= pwdata;
				REG_ANGLE_STEP:  cfg_q.angle_step  <= pwdata;
				REG_X_MIN:       cfg_q.x_min       <= pwdata[COORD_W-1:0];
				REG_X_MAX:       cfg_q.x_max       <= pwdata[COORD_W-1:0];
				REG_Y_MIN:       cfg_q.y_min       <= pwdata[COORD_W-1:0];
				REG_Y_MAX:       cfg_q.y_max       <= pwdata[COORD_W-1:0];
				default:         cfg_q.gate_lo     <= cfg_q.gate_lo;
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			REG_GATE_LO:     prdata = {16'b0, cfg_q.gate_lo};
			REG_GATE_HI:     prdata = {16'b0, cfg_q.gate_hi};
			REG_ANGLE_START: prdata = cfg_q.angle_start;
			REG_ANGLE_STEP:  prdata = cfg_q.angle_step;
			REG_X_MIN:       prdata = {{15{cfg_q.x_min[COORD_W-1]}}, cfg_q.x_min};
			REG_X_MAX:       prdata = {{15{cfg_q.x_max[COORD_W-1]}}, cfg_q.x_max};
			REG_Y_MIN:       prdata = {{15{cfg_q.y_min[COORD_W-1]}}, cfg_q.y_min};
			REG_Y_MAX:       prdata = {{15{cfg_q.y_max[COORD_W-1]}}, cfg_q.y_max};
			default:         prdata = '0;
		endcase
	end

	lsp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.cmd      (cmd),
		.sts      (sts)
	);

	lsp_dp #(
		.MAX_SAMPLES        (MAX_SAMPLES),
		.TRIG_FRACTION_BITS (TRIG_FRACTION_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.cfg          (cfg_q),
		.range_mm     (range_mm),
		.last_sample  (last_sample),
		.kept         (kept),
		.x_mm         (x_mm),
		.y_mm         (y_mm),
		.sample_index (sample_index),
		.end_of_scan  (end_of_scan),
		.out_valid    (out_valid),
		.out_stall    (out_stall)
	);

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input taken while a sample is in flight");

	a_dropped_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !kept) |-> (x_mm == '0 && y_mm == '0))
		else $error("dropped point carries nonzero coordinates");

	a_kept_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && kept) |-> (x_mm > $signed(cfg_q.x_min) && x_mm < $signed(cfg_q.x_max)
			&& y_mm > $signed(cfg_q.y_min) && y_mm < $signed(cfg_q.y_max)))
		else $error("kept point lies outside the workspace");

endmodule
`default_nettype wire

FILE: src/lsp_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lsp_ctrl
// Sequencer: walks one sample through angle, CORDIC, scaling and window steps.
// ----------------------------------------------------------------------------
module lsp_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	output lsp_pkg::lsp_cmd_t      cmd,
	input  wire lsp_pkg::lsp_sts_t sts
);
	import lsp_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_ANGLE, S_SETUP, S_ITER, S_TRIG, S_MULX, S_MULY, S_SATY, S_DONE
	} state_t;

	state_t            state_q;
	logic [STEP_W-1:0] step_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q  <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) state_q <= S_ANGLE;
				end
				S_ANGLE: state_q <= S_SETUP;
				S_SETUP: begin
					state_q <= S_ITER;
					step_q  <= '0;
				end
				S_ITER: begin
					if (step_q == STEP_LAST) state_q <= S_TRIG;
					step_q <= step_q + 1'b1;
				end
				S_TRIG: state_q <= S_MULX;
				S_MULX: state_q <= S_MULY;
				S_MULY: state_q <= S_SATY;
				S_SATY: state_q <= S_DONE;
				S_DONE: begin
					if (sts.out_free) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd      = '0;
		cmd.step = step_q;
		unique case (state_q)
			S_IDLE:  cmd.load   = in_valid;
			S_ANGLE: cmd.angle  = 1'b1;
			S_SETUP: cmd.setup  = 1'b1;
			S_ITER:  cmd.iter   = 1'b1;
			S_TRIG:  cmd.trig   = 1'b1;
			S_MULX:  cmd.mulx   = 1'b1;
			S_MULY:  cmd.muly   = 1'b1;
			S_SATY:  cmd.saty   = 1'b1;
			S_DONE:  cmd.finish = sts.out_free;
			default: cmd.load   = 1'b0;
		endcase
	end

	assign in_stall = (state_q != S_IDLE);

endmodule
`default_nettype wire

FILE: src/lsp_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lsp_dp
// Datapath: sample counter, beam angle, two-step-per-cycle CORDIC, range
// scaling with rounding and saturation, workspace window and output register.
// ----------------------------------------------------------------------------
module lsp_dp #(
	parameter int MAX_SAMPLES        = lsp_pkg::MAX_SAMPLES_DEF,
	parameter int TRIG_FRACTION_BITS = lsp_pkg::TRIG_FRAC_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire lsp_pkg::lsp_cmd_t               cmd,
	output lsp_pkg::lsp_sts_t                    sts,
	input  wire lsp_pkg::lsp_cfg_t               cfg,
	input  wire logic [lsp_pkg::RANGE_W-1:0]     range_mm,
	input  wire logic                            last_sample,
	output logic                                 kept,
	output logic signed [lsp_pkg::COORD_W-1:0]   x_mm,
	output logic signed [lsp_pkg::COORD_W-1:0]   y_mm,
	output logic [lsp_pkg::IDX_W-1:0]            sample_index,
	output logic                                 end_of_scan,
	output logic                                 out_valid,
	input  wire logic                            out_stall
);
	import lsp_pkg::*;

	localparam int CNT_TOP_I = (MAX_SAMPLES - 1 < 4095) ? MAX_SAMPLES - 1 : 4095;
	localparam logic [IDX_W-1:0] CNT_TOP = IDX_W'(CNT_TOP_I);
	localparam int RS  = CORDIC_Q - TRIG_FRACTION_BITS;
	localparam int T_W = TRIG_FRACTION_BITS + 3;
	localparam int P_W = RANGE_W + 1 + T_W;
	localparam logic signed [CORDIC_W-1:0] TRIG_HALF = CORDIC_W'(1) << (RS - 1);
	localparam logic signed [P_W-1:0] MM_HALF = P_W'(1) << (TRIG_FRACTION_BITS - 1);
	localparam logic signed [P_W-1:0] LIM_P   = P_W'(COORD_LIMIT);
	localparam logic signed [P_W-1:0] LIM_N   = -LIM_P;

	function automatic logic signed [COORD_W-1:0] sat_mm(input logic signed [P_W-1:0] p);
		logic signed [P_W-1:0] s;
		logic signed [P_W-1:0] v;
		s = p + MM_HALF;
		v = s >>> TRIG_FRACTION_BITS;
		if (v > LIM_P) return COORD_W'(COORD_LIMIT);
		if (v < LIM_N) return -COORD_W'(COORD_LIMIT);
		return COORD_W'(v);
	endfunction

	logic [IDX_W-1:0]           cnt_q;
	logic [IDX_W-1:0]           idx_q;
	logic [RANGE_W-1:0]         range_q;
	logic                       last_q;
	logic [ANGLE_W-1:0]         angp_q;
	logic [1:0]                 quad_q;
	logic signed [CORDIC_W-1:0] cx_q, cy_q, cz_q;
	logic signed [T_W-1:0]      c_q, s_q;
	logic signed [P_W-1:0]      prod_q;
	logic signed [COORD_W-1:0]  xs_q, ys_q;
	logic                       kept_q, eos_q, out_valid_q;
	logic signed [COORD_W-1:0]  x_out_q, y_out_q;
	logic [IDX_W-1:0]           idx_out_q;

	logic [IDX_W+ANGLE_W-1:0]   angp_w;
	logic [ANGLE_W-1:0]         shifted_w;
	logic signed [CORDIC_W-1:0] z_init_w;
	logic [4:0]                 i0, i1;
	logic signed [CORDIC_W-1:0] x1, y1, z1, x2, y2, z2;
	logic signed [CORDIC_W-1:0] xsum_w, ysum_w, xr_full, yr_full;
	logic signed [T_W-1:0]      xr_w, yr_w, c_w, s_w;
	logic signed [P_W-1:0]      prod_w;
	logic                       gate_w, keep_w;

	assign angp_w    = idx_q * cfg.angle_step;
	assign shifted_w = cfg.angle_start + angp_q + EIGHTH_TURN;
	assign z_init_w  = $signed({4'b0, shifted_w[29:0]}) - $signed(CORDIC_W'(EIGHTH_TURN));

	always_comb begin
		i0 = {cmd.step, 1'b0};
		i1 = {cmd.step, 1'b1};
		if (!cz_q[CORDIC_W-1]) begin
			x1 = cx_q - (cy_q >>> i0);
			y1 = cy_q + (cx_q >>> i0);
			z1 = cz_q - $signed(atan_turn(i0));
		end else begin
			x1 = cx_q + (cy_q >>> i0);
			y1 = cy_q - (cx_q >>> i0);
			z1 = cz_q + $signed(atan_turn(i0));
		end
		if (!z1[CORDIC_W-1]) begin
			x2 = x1 - (y1 >>> i1);
			y2 = y1 + (x1 >>> i1);
			z2 = z1 - $signed(atan_turn(i1));
		end else begin
			x2 = x1 + (y1 >>> i1);
			y2 = y1 - (x1 >>> i1);
			z2 = z1 + $signed(atan_turn(i1));
		end
	end

	always_comb begin
		xsum_w  = cx_q + TRIG_HALF;
		ysum_w  = cy_q + TRIG_HALF;
		xr_full = xsum_w >>> RS;
		yr_full = ysum_w >>> RS;
		xr_w    = T_W'(xr_full);
		yr_w    = T_W'(yr_full);
		case (quad_q)
			2'd0: begin c_w = xr_w;  s_w = yr_w;  end
			2'd1: begin c_w = -yr_w; s_w = xr_w;  end
			2'd2: begin c_w = -xr_w; s_w = -yr_w; end
			default: begin c_w = yr_w; s_w = -xr_w; end
		endcase
	end

	assign prod_w = $signed({1'b0, range_q}) * (cmd.mulx ? c_q : s_q);

	assign gate_w = (range_q >= cfg.gate_lo) && (range_q <= cfg.gate_hi);
	assign keep_w = gate_w
		&& (xs_q > $signed(cfg.x_min)) && (xs_q < $signed(cfg.x_max))
		&& (ys_q > $signed(cfg.y_min)) && (ys_q < $signed(cfg.y_max));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				if (last_sample) cnt_q <= '0;
				else if (cnt_q < CNT_TOP) cnt_q <= cnt_q + 1'b1;
			end
			if (cmd.finish) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			idx_q   <= cnt_q;
			range_q <= range_mm;
			last_q  <= last_sample;
		end
		if (cmd.angle) angp_q <= angp_w[ANGLE_W-1:0];
		if (cmd.setup) begin
			quad_q <= shifted_w[31:30];
			cx_q   <= $signed(CORDIC_W'(CORDIC_GAIN));
			cy_q   <= '0;
			cz_q   <= z_init_w;
		end
		if (cmd.iter) begin
			cx_q <= x2;
			cy_q <= y2;
			cz_q <= z2;
		end
		if (cmd.trig) begin
			c_q <= c_w;
			s_q <= s_w;
		end
		if (cmd.mulx || cmd.muly) prod_q <= prod_w;
		if (cmd.muly) xs_q <= sat_mm(prod_q);
		if (cmd.saty) ys_q <= sat_mm(prod_q);
		if (cmd.finish) begin
			kept_q    <= keep_w;
			x_out_q   <= keep_w ? xs_q : '0;
			y_out_q   <= keep_w ? ys_q : '0;
			idx_out_q <= idx_q;
			eos_q     <= last_q;
		end
	end

	assign sts.out_free = !out_valid_q || !out_stall;
	assign kept         = kept_q;
	assign x_mm         = x_out_q;
	assign y_mm         = y_out_q;
	assign sample_index = idx_out_q;
	assign end_of_scan  = eos_q;
	assign out_valid    = out_valid_q;

endmodule
`default_nettype wire

FILE: tb/scan_point_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// scan_point_checker
// Watches the sample, point and register ports of the laser scan to points
// block. Register writes update a private copy of the settings, every sample
// beat is projected to the point it must produce, and every point beat is
// compared field by field with the oldest projection still outstanding.
// ----------------------------------------------------------------------------
package scan_roi_tb_pkg;

	typedef enum logic [2:0] {
		REG_GATE_LO,
		REG_GATE_HI,
		REG_ANGLE_START,
		REG_ANGLE_STEP,
		REG_X_MIN,
		REG_X_MAX,
		REG_Y_MIN,
		REG_Y_MAX
	} roi_reg_e;

endpackage

module scan_point_checker #(
	parameter int MAX_SAMPLES        = lsp_pkg::MAX_SAMPLES_DEF,
	parameter int TRIG_FRACTION_BITS = lsp_pkg::TRIG_FRAC_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic [lsp_pkg::RANGE_W-1:0]         range_mm,
	input  logic                                last_sample,
	input  logic                                in_valid,
	input  logic                                in_stall,
	input  logic                                kept,
	input  logic signed [lsp_pkg::COORD_W-1:0]  x_mm,
	input  logic signed [lsp_pkg::COORD_W-1:0]  y_mm,
	input  logic [lsp_pkg::IDX_W-1:0]           sample_index,
	input  logic                                end_of_scan,
	input  logic                                out_valid,
	input  logic                                out_stall,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [4:0]                          paddr,
	input  logic [31:0]                         pwdata,
	input  logic                                pready,
	output int                                  pending,
	output int                                  mismatches
);
	import scan_roi_tb_pkg::*;

	localparam int COUNT_TOP = (MAX_SAMPLES - 1 < 4095) ? MAX_SAMPLES - 1 : 4095;
	localparam int ROT_STEPS = 30;
	localparam longint COORD_MAX = 65535;

	typedef enum logic [1:0] {QUAD_EAST, QUAD_NORTH, QUAD_WEST, QUAD_SOUTH} quadrant_e;

	typedef struct {
		logic                               kept;
		logic signed [lsp_pkg::COORD_W-1:0] x;
		logic signed [lsp_pkg::COORD_W-1:0] y;
		logic [lsp_pkg::IDX_W-1:0]          idx;
		logic                               eos;
	} scan_point_t;

	longint atan_lut [0:ROT_STEPS-1] = '{
		64'h20000000, 64'h12E4051D, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
		64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2E,
		64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2F9,
		64'h0000517C, 64'h000028BE, 64'h0000145F, 64'h00000A2F, 64'h00000517,
		64'h0000028B, 64'h00000145, 64'h000000A2, 64'h00000051, 64'h00000028,
		64'h00000014, 64'h0000000A, 64'h00000005, 64'h00000002, 64'h00000001
	};

	logic [15:0]             gate_lo, gate_hi;
	logic [31:0]             sweep_start, sweep_step;
	int                      win_x_lo, win_x_hi, win_y_lo, win_y_hi;
	logic [lsp_pkg::IDX_W-1:0] beam_count;
	scan_point_t             pending_points [$];
	int                      fail_count = 0;

	function automatic longint round_half_up(input longint v, input int s);
		return (v + (longint'(1) << (s - 1))) >>> s;
	endfunction

	function automatic void beam_trig(input logic [31:0] angle, output longint c,
			output longint s);
		logic [31:0] shifted;
		quadrant_e   quad;
		longint      z, xr, yr, dx, dy, cr, sr;
		shifted = angle + lsp_pkg::EIGHTH_TURN;
		quad = quadrant_e'(shifted[31:30]);
		z = longint'(shifted[29:0]) - longint'(lsp_pkg::EIGHTH_TURN);
		xr = longint'(lsp_pkg::CORDIC_GAIN);
		yr = 0;
		for (int i = 0; i < ROT_STEPS; i++) begin
			dx = yr >>> i;
			dy = xr >>> i;
			if (z >= 0) begin
				xr = xr - dx;
				yr = yr + dy;
				z = z - atan_lut[i];
			end else begin
				xr = xr + dx;
				yr = yr - dy;
				z = z + atan_lut[i];
			end
		end
		cr = round_half_up(xr, 30 - TRIG_FRACTION_BITS);
		sr = round_half_up(yr, 30 - TRIG_FRACTION_BITS);
		case (quad)
			QUAD_EAST: begin
				c = cr;
				s = sr;
			end
			QUAD_NORTH: begin
				c = -sr;
				s = cr;
			end
			QUAD_WEST: begin
				c = -cr;
				s = -sr;
			end
			default: begin
				c = sr;
				s = -cr;
			end
		endcase
	endfunction

	function automatic longint scale_mm(input logic [15:0] range_v, input longint t);
		longint v;
		v = round_half_up(longint'(range_v) * t, TRIG_FRACTION_BITS);
		if (v > COORD_MAX)
			return COORD_MAX;
		if (v < -COORD_MAX)
			return -COORD_MAX;
		return v;
	endfunction

	function automatic scan_point_t project_beam(input logic [15:0] range_v,
			input logic last_v);
		scan_point_t p;
		logic [31:0] angle;
		longint      c, s, xv, yv;
		p.kept = 1'b0;
		p.x = '0;
		p.y = '0;
		p.idx = beam_count;
		p.eos = last_v;
		if (range_v >= gate_lo && range_v <= gate_hi) begin
			angle = sweep_start + 32'(beam_count) * sweep_step;
			beam_trig(angle, c, s);
			xv = scale_mm(range_v, c);
			yv = scale_mm(range_v, s);
			if (xv > win_x_lo && xv < win_x_hi && yv > win_y_lo && yv < win_y_hi) begin
				p.kept = 1'b1;
				p.x = xv[16:0];
				p.y = yv[16:0];
			end
		end
		return p;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		scan_point_t want;
		if (!arst_n) begin
			gate_lo = 16'd0;
			gate_hi = 16'd65535;
			sweep_start = '0;
			sweep_step = '0;
			win_x_lo = 500;
			win_x_hi = 1500;
			win_y_lo = -500;
			win_y_hi = 500;
			beam_count = '0;
			pending_points.delete();
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (roi_reg_e'(paddr[4:2]))
					REG_GATE_LO:     gate_lo = pwdata[15:0];
					REG_GATE_HI:     gate_hi = pwdata[15:0];
					REG_ANGLE_START: sweep_start = pwdata;
					REG_ANGLE_STEP:  sweep_step = pwdata;
					REG_X_MIN:       win_x_lo = $signed(pwdata[16:0]);
					REG_X_MAX:       win_x_hi = $signed(pwdata[16:0]);
					REG_Y_MIN:       win_y_lo = $signed(pwdata[16:0]);
					default:         win_y_hi = $signed(pwdata[16:0]);
				endcase
			end
			if (out_valid && !out_stall) begin
				if (pending_points.size() == 0) begin
					$error("point beat with no sample outstanding");
					fail_count++;
				end else begin
					want = pending_points.pop_front();
					if (kept !== want.kept) begin
						$error("kept: expected %0d, got %0d", want.kept, kept);
						fail_count++;
					end
					if (x_mm !== want.x) begin
						$error("x_mm: expected %0d, got %0d", want.x, x_mm);
						fail_count++;
					end
					if (y_mm !== want.y) begin
						$error("y_mm: expected %0d, got %0d", want.y, y_mm);
						fail_count++;
					end
					if (sample_index !== want.idx) begin
						$error("sample_index: expected %0d, got %0d", want.idx,
							sample_index);
						fail_count++;
					end
					if (end_of_scan !== want.eos) begin
						$error("end_of_scan: expected %0d, got %0d", want.eos,
							end_of_scan);
						fail_count++;
					end
				end
			end
			if (in_valid && !in_stall) begin
				pending_points.insert(pending_points.size(),
					project_beam(range_mm, last_sample));
				if (last_sample)
					beam_count = '0;
				else if (beam_count < COUNT_TOP)
					beam_count = beam_count + 1'b1;
			end
		end
		pending <= pending_points.size();
		mismatches <= fail_count;
	end

endmodule

FILE: tb/tb_laser_scan_to_points_roi.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_laser_scan_to_points_roi
// Drives laser scans into the scan to points block: a directed pass over the
// range gate, window edges, quadrants and inverted or empty settings, then
// random scans under random register settings with random gaps and output
// stalls. The checker beside the block predicts and compares every point beat.
// ----------------------------------------------------------------------------
module tb_laser_scan_to_points_roi;
	import scan_roi_tb_pkg::*;

	localparam int ITEM_TARGET  = 1550;
	localparam int CYCLE_LIMIT  = 500000;

	logic                               clk = 1'b0;
	logic                               arst_n = 1'b0;
	logic [lsp_pkg::RANGE_W-1:0]        range_mm = '0;
	logic                               last_sample = 1'b0;
	logic                               in_valid = 1'b0;
	logic                               in_stall;
	logic                               kept;
	logic signed [lsp_pkg::COORD_W-1:0] x_mm;
	logic signed [lsp_pkg::COORD_W-1:0] y_mm;
	logic [lsp_pkg::IDX_W-1:0]          sample_index;
	logic                               end_of_scan;
	logic                               out_valid;
	logic                               out_stall = 1'b0;
	logic                               psel = 1'b0;
	logic                               penable = 1'b0;
	logic                               pwrite = 1'b0;
	logic [4:0]                         paddr = '0;
	logic [31:0]                        pwdata = '0;
	logic [31:0]                        prdata;
	logic                               pready;

	int pending;
	int mismatches;
	int beats_sent = 0;
	int cycles = 0;
	bit quiet = 1'b0;

	laser_scan_to_points_roi u_dut (
		.clk(clk), .arst_n(arst_n),
		.range_mm(range_mm), .last_sample(last_sample),
		.in_valid(in_valid), .in_stall(in_stall),
		.kept(kept), .x_mm(x_mm), .y_mm(y_mm),
		.sample_index(sample_index), .end_of_scan(end_of_scan),
		.out_valid(out_valid), .out_stall(out_stall),
		.psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	scan_point_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.range_mm(range_mm), .last_sample(last_sample),
		.in_valid(in_valid), .in_stall(in_stall),
		.kept(kept), .x_mm(x_mm), .y_mm(y_mm),
		.sample_index(sample_index), .end_of_scan(end_of_scan),
		.out_valid(out_valid), .out_stall(out_stall),
		.psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .pready(pready),
		.pending(pending), .mismatches(mismatches)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	function automatic int draw_wait();
		return quiet ? 0 : int'($urandom_range(0, 17));
	endfunction

	function automatic logic [31:0] with_junk(input logic [31:0] v, input int w);
		logic [31:0] keep;
		keep = (32'd1 << w) - 32'd1;
		return (v & keep) | ($urandom & ~keep);
	endfunction

	function automatic logic [15:0] draw_range(input int lo, input int hi);
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return '1;
			2, 3:    return 16'($urandom);
			default: return 16'($urandom_range(lo, hi));
		endcase
	endfunction

	function automatic int draw_coord(input int span);
		return int'($urandom_range(0, 2 * span)) - span;
	endfunction

	task automatic feed_beam(input logic [15:0] r, input logic last);
		int gap;
		gap = draw_wait();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		range_mm <= r;
		last_sample <= last;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		beats_sent++;
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	task automatic write_reg(input roi_reg_e idx, input logic [31:0] v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic load_roi(input int rmin, input int rmax, input logic [31:0] start,
			input logic [31:0] step, input int xlo, input int xhi, input int ylo,
			input int yhi);
		write_reg(REG_GATE_LO, with_junk(32'(rmin), 16));
		write_reg(REG_GATE_HI, with_junk(32'(rmax), 16));
		write_reg(REG_ANGLE_START, start);
		write_reg(REG_ANGLE_STEP, step);
		write_reg(REG_X_MIN, with_junk(32'(xlo), 17));
		write_reg(REG_X_MAX, with_junk(32'(xhi), 17));
		write_reg(REG_Y_MIN, with_junk(32'(ylo), 17));
		write_reg(REG_Y_MAX, with_junk(32'(yhi), 17));
	endtask

	initial begin
		int hold;
		forever begin
			hold = draw_wait();
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!(out_valid && !out_stall));
		end
	end

	initial begin
		int          rmin, rmax, reach, span, xlo, xhi, ylo, yhi, swap, phase_len, scan_left;
		logic [31:0] start, step;
		scan_left = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: beam along +x, window 500..1500 by -500..500
		feed_beam(16'd0, 1'b0);
		feed_beam(16'd1000, 1'b0);
		feed_beam(16'd65535, 1'b0);
		feed_beam(16'd500, 1'b0);
		feed_beam(16'd1499, 1'b0);
		feed_beam(16'd1500, 1'b1);
		settle();

		// quarter-turn steps through all quadrants, gate edges
		load_roi(100, 65534, 32'h0, 32'h4000_0000, -65535, 65535, -65535, 65535);
		feed_beam(16'd99, 1'b0);
		feed_beam(16'd100, 1'b0);
		feed_beam(16'd65534, 1'b0);
		feed_beam(16'd65535, 1'b0);
		feed_beam(16'd4000, 1'b0);
		feed_beam(16'd4000, 1'b1);
		settle();

		// inverted gate and inverted window
		load_roi(3000, 2000, 32'h2000_0000, 32'hFFFF_FFFF, 100, -100, -65535, 65535);
		feed_beam(16'd2500, 1'b0);
		feed_beam(16'd0, 1'b0);
		feed_beam(16'd65535, 1'b1);
		settle();

		// residual just below an octant edge, odd step
		load_roi(0, 65535, 32'hDFFF_FFFF, 32'h4000_0001, -65535, 65535, -65535, 65535);
		feed_beam(16'd0, 1'b0);
		feed_beam(16'd65535, 1'b0);
		feed_beam(16'd32768, 1'b0);
		feed_beam(16'd1, 1'b0);
		feed_beam(16'd65535, 1'b1);
		settle();

		// empty window
		load_roi(0, 65535, 32'h0, 32'h1000_0000, 1000, 1000, -65535, 65535);
		feed_beam(16'd1200, 1'b0);
		feed_beam(16'd1200, 1'b1);

		while (beats_sent < ITEM_TARGET) begin
			settle();
			rmin = ($urandom_range(0, 1) == 0) ? 0 : int'($urandom_range(0, 3000));
			if ($urandom_range(0, 30) == 0)
				rmin = 65535;
			case ($urandom_range(0, 5))
				0, 1, 2: rmax = 65535;
				3:       rmax = int'($urandom_range(0, rmin));
				default: rmax = int'($urandom_range(rmin, 65535));
			endcase
			start = $urandom;
			case ($urandom_range(0, 5))
				0:       step = '0;
				1:       step = '1;
				2:       step = $urandom;
				default: step = 32'(64'h1_0000_0000 / $urandom_range(16, 2048));
			endcase
			reach = ($urandom_range(0, 2) == 0) ? 65535 : int'($urandom_range(300, 6000));
			span = (reach + 500 > 65535) ? 65535 : reach + 500;
			case ($urandom_range(0, 7))
				0: begin
					xlo = -65535;
					xhi = 65535;
					ylo = -65535;
					yhi = 65535;
				end
				1: begin
					xlo = draw_coord(span);
					xhi = xlo;
					ylo = draw_coord(span);
					yhi = draw_coord(span);
				end
				default: begin
					xlo = draw_coord(span);
					xhi = draw_coord(span);
					ylo = draw_coord(span);
					yhi = draw_coord(span);
					if (xlo > xhi) begin
						swap = xlo;
						xlo = xhi;
						xhi = swap;
					end
					if (ylo > yhi) begin
						swap = ylo;
						ylo = yhi;
						yhi = swap;
					end
				end
			endcase
			// flip the window now and then
			if ($urandom_range(0, 15) == 0) begin
				swap = ylo;
				ylo = yhi;
				yhi = swap;
			end
			load_roi(rmin, rmax, start, step, xlo, xhi, ylo, yhi);
			quiet = ($urandom_range(0, 3) == 0);

			phase_len = $urandom_range(20, 90);
			repeat (phase_len) begin
				if (scan_left == 0)
					scan_left = ($urandom_range(0, 9) == 0) ?
						int'($urandom_range(100, 400)) : int'($urandom_range(1, 48));
				feed_beam(draw_range(rmin, (rmax < reach) ? rmax : reach),
					scan_left == 1 || $urandom_range(0, 99) == 0);
				scan_left--;
			end
		end

		settle();
		repeat (40) @(posedge clk);
		if (mismatches == 0 && pending == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

FILE: laser_scan_to_points_roi.f
src/lsp_pkg.sv
src/lsp_ctrl.sv
src/lsp_dp.sv
src/laser_scan_to_points_roi.sv
tb/scan_point_checker.sv
tb/tb_laser_scan_to_points_roi.sv
